>>> rtl/pcc_pkg.sv
package pcc_pkg;

  // longest frame that can still pass the check
  localparam int unsigned MaxFrameBytes = 128;

  localparam logic [15:0] CrcPoly   = 16'h1021;
  localparam logic [15:0] CrcMsb    = 16'h8000;
  localparam logic [15:0] CrcHiMask = 16'hFF00;
  localparam logic [15:0] CrcLoMask = 16'h00FF;

  localparam logic [7:0] CtrlHello = 8'h48;  // 'H'
  localparam logic [7:0] CtrlNbrs  = 8'h4E;  // 'N'
  localparam logic [7:0] CtrlMsg   = 8'h4D;  // 'M'
  localparam logic [7:0] CtrlSingle = 8'h53; // 'S'
  localparam logic [7:0] CtrlDouble = 8'h44; // 'D'
  localparam logic [7:0] CtrlFlood = 8'h46;  // 'F', any other second control floods

  localparam logic [7:0] CountMax = 8'hFF;

  typedef enum logic [2:0] {
    PKT_CORRUPT = 3'd0,
    PKT_HELLO   = 3'd1,
    PKT_NBRS    = 3'd2,
    PKT_FOR_ME  = 3'd3,
    PKT_RELAY   = 3'd4,
    PKT_DROP    = 3'd5,
    PKT_NONE    = 3'd6,
    PKT_FLOOD   = 3'd7
  } pkt_type_e;

  typedef struct packed {
    pkt_type_e   packet_type;
    logic [7:0]  source_address;
    logic [7:0]  dest_address;
    logic [15:0] computed_crc;
  } result_t;

  // one byte through crc-16 xmodem, msb first
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcMsb) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // zero crc bytes are sent as 0xff
  function automatic logic [15:0] crc_patch(input logic [15:0] crc);
    logic [15:0] c;
    c = crc;
    if ((c & CrcHiMask) == 16'h0000) begin
      c = c | CrcHiMask;
    end
    if ((c & CrcLoMask) == 16'h0000) begin
      c = c | CrcLoMask;
    end
    return c;
  endfunction

endpackage

>>> rtl/pcc_intf.sv
interface pcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       no_packet;

  modport source (output valid, data_byte, last_byte, no_packet, input ready);
  modport sink (input valid, data_byte, last_byte, no_packet, output ready);
endinterface

interface pcc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  packet_type;
  logic [7:0]  source_address;
  logic [7:0]  dest_address;
  logic [15:0] computed_crc;

  modport source (output valid, packet_type, source_address, dest_address, computed_crc,
                  input ready);
  modport sink (input valid, packet_type, source_address, dest_address, computed_crc,
                output ready);
endinterface

interface pcc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] own_address;

  modport source (output valid, own_address, input ready);
  modport sink (input valid, own_address, output ready);
endinterface

>>> rtl/packet_crc_check_classifier_core.sv
// Frame checker and classifier for a byte-wide link receiver. Each input beat carries
// one frame byte with a last-byte mark, or an empty poll (no_packet). A CRC-16 XModem
// (poly 0x1021, init 0) runs over all bytes but the final two, zero CRC bytes are
// forced to 0xFF, and the result is compared with the trailer, high byte first. The
// last byte of a frame, or an empty poll, yields one result beat; middle bytes yield
// none. Frames under four bytes or over 128 bytes report corrupt. One input beat is
// taken per clock while the skid entry is empty; results are registered in the
// output register, or in the skid entry on a stall. A two-entry output buffer keeps
// input beats flowing while one result waits downstream. own_address is to be written
// over the config channel only while the block is idle; this is not enforced.
module packet_crc_check_classifier_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  pcc_in_if.sink    in_i,
  pcc_cfg_if.sink   cfg_i,
  pcc_out_if.source out_o
);

  // frame state
  logic [15:0] crc_q, crc_d;
  logic [7:0]  held0_q, held0_d;
  logic [7:0]  held1_q, held1_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  ctrl0_q, ctrl0_d;
  logic [7:0]  ctrl1_q, ctrl1_d;
  logic [7:0]  sender_q, sender_d;
  logic [7:0]  target_q, target_d;
  logic [7:0]  own_addr_q;

  // output buffer: main register plus skid entry
  logic                 out_valid_q, skid_valid_q;
  pcc_pkg::result_t     out_data_q, skid_data_q;

  logic                 in_fire;
  logic                 res_valid;
  pcc_pkg::result_t     res;

  assign in_i.ready  = ~skid_valid_q;
  assign in_fire     = in_i.valid & in_i.ready;
  assign cfg_i.ready = 1'b1;

  // per-beat update and result
  always_comb begin
    logic [15:0] n_crc;
    logic [7:0]  n_h0, n_h1, n_cnt, n_c0, n_c1, n_src, n_dst;
    logic [15:0] patched;
    logic        ok;
    crc_d    = crc_q;
    held0_d  = held0_q;
    held1_d  = held1_q;
    count_d  = count_q;
    ctrl0_d  = ctrl0_q;
    ctrl1_d  = ctrl1_q;
    sender_d = sender_q;
    target_d = target_q;
    res_valid = 1'b0;
    res = '{packet_type: pcc_pkg::PKT_NONE, source_address: 8'h00,
            dest_address: 8'h00, computed_crc: 16'h0000};

    // take the byte
    n_c0  = (count_q == 8'd0) ? in_i.data_byte : ctrl0_q;
    n_c1  = (count_q == 8'd1) ? in_i.data_byte : ctrl1_q;
    n_src = (count_q == 8'd2) ? in_i.data_byte : sender_q;
    n_dst = (count_q == 8'd3) ? in_i.data_byte : target_q;
    n_crc = (count_q >= 8'd2) ? pcc_pkg::crc_update(crc_q, held0_q) : crc_q;
    n_h0  = held1_q;
    n_h1  = in_i.data_byte;
    n_cnt = (count_q != pcc_pkg::CountMax) ? count_q + 8'd1 : count_q;

    patched = pcc_pkg::crc_patch(n_crc);
    ok = (n_cnt >= 8'd4) && (n_cnt <= 8'(pcc_pkg::MaxFrameBytes)) &&
         (n_h0 == patched[15:8]) && (n_h1 == patched[7:0]);

    if (in_fire) begin
      if (in_i.no_packet) begin
        // empty poll: drop any partial frame
        res_valid = 1'b1;
        crc_d = 16'h0000; held0_d = 8'h00; held1_d = 8'h00; count_d = 8'h00;
        ctrl0_d = 8'h00; ctrl1_d = 8'h00; sender_d = 8'h00; target_d = 8'h00;
      end else if (in_i.last_byte) begin
        res_valid = 1'b1;
        res.source_address = n_src;
        res.dest_address   = n_dst;
        res.computed_crc   = patched;
        if (!ok) begin
          res.packet_type = pcc_pkg::PKT_CORRUPT;
        end else if (n_c0 == pcc_pkg::CtrlHello) begin
          res.packet_type = pcc_pkg::PKT_HELLO;
        end else if (n_c0 == pcc_pkg::CtrlNbrs) begin
          res.packet_type = pcc_pkg::PKT_NBRS;
        end else if (n_c0 == pcc_pkg::CtrlMsg) begin
          if (n_dst == own_addr_q) begin
            res.packet_type = pcc_pkg::PKT_FOR_ME;
          end else if (n_c1 == pcc_pkg::CtrlSingle) begin
            res.packet_type = pcc_pkg::PKT_DROP;
          end else if (n_c1 == pcc_pkg::CtrlDouble) begin
            res.packet_type = pcc_pkg::PKT_RELAY;
          end else begin
            res.packet_type = pcc_pkg::PKT_FLOOD;
          end
        end else begin
          res.packet_type = pcc_pkg::PKT_NONE;
        end
        // frame done, back to reset values
        crc_d = 16'h0000; held0_d = 8'h00; held1_d = 8'h00; count_d = 8'h00;
        ctrl0_d = 8'h00; ctrl1_d = 8'h00; sender_d = 8'h00; target_d = 8'h00;
      end else begin
        crc_d = n_crc; held0_d = n_h0; held1_d = n_h1; count_d = n_cnt;
        ctrl0_d = n_c0; ctrl1_d = n_c1; sender_d = n_src; target_d = n_dst;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= 16'h0000;
      held0_q    <= 8'h00;
      held1_q    <= 8'h00;
      count_q    <= 8'h00;
      ctrl0_q    <= 8'h00;
      ctrl1_q    <= 8'h00;
      sender_q   <= 8'h00;
      target_q   <= 8'h00;
      own_addr_q <= 8'h00;
    end else begin
      crc_q    <= crc_d;
      held0_q  <= held0_d;
      held1_q  <= held1_d;
      count_q  <= count_d;
      ctrl0_q  <= ctrl0_d;
      ctrl1_q  <= ctrl1_d;
      sender_q <= sender_d;
      target_q <= target_d;
      if (cfg_i.valid) begin
        own_addr_q <= cfg_i.own_address;
      end
    end
  end

  // output buffer control; the skid entry only fills while the main register stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_o.ready) begin
      out_data_q <= skid_valid_q ? skid_data_q : res;
    end else if (res_valid) begin
      skid_data_q <= res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.packet_type    = out_data_q.packet_type;
  assign out_o.source_address = out_data_q.source_address;
  assign out_o.dest_address   = out_data_q.dest_address;
  assign out_o.computed_crc   = out_data_q.computed_crc;

endmodule
